@@ rtl/core/ett_pkg.sv @@
`default_nettype none
package ett_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int WORD_W   = 64;

    localparam logic [KIND_W-1:0] KIND_STORE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FKEY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FADDR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOINIT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word and start a pass
        logic step;      // read the slot at the walk index
        logic finish;    // perform the end-of-operation decision
        logic emit;      // drop the result into the output register
    } ett_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // walk index reached the end of this pass
        logic hit;       // the slot just examined ends the walk
        logic again;     // a store without a key match needs the free-slot pass
    } ett_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/ett_datapath.sv @@
`default_nettype none
module ett_datapath
    import ett_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 64,
    parameter int ADDR_BITS   = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [COUNT_W-1:0]  cfg_wr_data,
    input  wire ett_cmd_t            cmd,
    output ett_stat_t                stat,
    input  wire logic [KIND_W-1:0]   in_kind,
    input  wire logic [WORD_W-1:0]   in_now,
    input  wire logic [WORD_W-1:0]   in_key,
    input  wire logic [WORD_W-1:0]   in_addr,
    input  wire logic [WORD_W-1:0]   in_expiry,
    input  wire logic [WORD_W-1:0]   in_note,
    input  wire logic [COUNT_W-1:0]  in_budget,
    output logic [STATUS_W-1:0]      res_status,
    output logic [SLOT_W-1:0]        res_slot,
    output logic [WORD_W-1:0]        res_key,
    output logic [WORD_W-1:0]        res_addr,
    output logic [WORD_W-1:0]        res_expiry,
    output logic [WORD_W-1:0]        res_note,
    output logic [COUNT_W-1:0]       res_freed,
    output logic [COUNT_W-1:0]       res_live
);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Entry storage; live bits in flip-flops, payload in memories with a
    // registered read port at the next walk index.
    logic [TABLE_DEPTH-1:0] live_reg, live_next;
    logic [KEY_BITS-1:0]    mem_key    [TABLE_DEPTH];
    logic [ADDR_BITS-1:0]   mem_addr   [TABLE_DEPTH];
    logic [WORD_W-1:0]      mem_expiry [TABLE_DEPTH];
    logic [WORD_W-1:0]      mem_note   [TABLE_DEPTH];
    logic [KEY_BITS-1:0]    rd_key_reg;
    logic [ADDR_BITS-1:0]   rd_addr_reg;
    logic [WORD_W-1:0]      rd_exp_reg;
    logic [WORD_W-1:0]      rd_note_reg;

    logic [CNT_W-1:0] size_reg, size_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] live_total_reg, live_total_next;

    // Captured operation.
    logic [KIND_W-1:0]    kind_reg;
    logic [WORD_W-1:0]    now_reg, exp_reg, note_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    // Walk state.
    logic [CNT_W-1:0] walk_reg, walk_next;       // steps taken
    logic [CNT_W-1:0] limit_reg, limit_next;     // steps in this pass
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pass2_reg, pass2_next;     // free-slot pass of a store
    logic             found_reg, found_next;
    logic [IDX_W-1:0] fslot_reg, fslot_next;
    logic             exp_ok_reg, exp_ok_next;
    logic [IDX_W-1:0] exp_slot_reg, exp_slot_next;
    logic             old_ok_reg, old_ok_next;
    logic [IDX_W-1:0] old_slot_reg, old_slot_next;
    logic [WORD_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] freed_reg, freed_next;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    // Output register.
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [IDX_W-1:0]    o_slot_reg, o_slot_next;
    logic [WORD_W-1:0]   o_key_reg, o_key_next;
    logic [WORD_W-1:0]   o_addr_reg, o_addr_next;
    logic [WORD_W-1:0]   o_exp_reg, o_exp_next;
    logic [WORD_W-1:0]   o_note_reg, o_note_next;
    logic [COUNT_W-1:0]  o_freed_reg, o_freed_next;
    logic [COUNT_W-1:0]  o_live_reg, o_live_next;

    logic [CNT_W-1:0] cfg_sat;
    logic [IDX_W-1:0] cursor_inc;
    logic             is_live, is_expired, key_eq, addr_eq;
    logic [IDX_W-1:0] cur;

    assign cfg_sat = (CMP_W'(cfg_wr_data) > CMP_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                     : CNT_W'(cfg_wr_data);

    // The read registers always hold the entry at the walk index.
    assign cur        = idx_reg;
    assign is_live    = live_reg[cur];
    assign is_expired = rd_exp_reg <= now_reg;
    assign key_eq     = rd_key_reg == key_reg;
    assign addr_eq    = rd_addr_reg == addr_reg;

    // Next index, wrapping at the table size for the sweep cursor.
    always_comb begin
        if (CNT_W'(cursor_reg) + CNT_W'(1) >= size_reg) begin
            cursor_inc = '0;
        end else begin
            cursor_inc = cursor_reg + IDX_W'(1);
        end
    end

    // Status toward the controller.
    always_comb begin
        stat       = '0;
        stat.last  = (walk_reg >= limit_reg);
        stat.again = (kind_reg == KIND_STORE) && !found_reg && !pass2_reg;
        if (!pass2_reg) begin
            case (kind_reg)
                KIND_STORE: stat.hit = is_live && key_eq;
                KIND_FKEY:  stat.hit = is_live && key_eq && !is_expired;
                KIND_FADDR: stat.hit = is_live && !is_expired && addr_eq;
                default:    stat.hit = 1'b0;
            endcase
        end else begin
            stat.hit = !is_live;
        end
    end

    // Datapath next-state logic.
    always_comb begin
        live_next       = live_reg;
        size_next       = size_reg;
        cursor_next     = cursor_reg;
        live_total_next = live_total_reg;
        walk_next       = walk_reg;
        limit_next      = limit_reg;
        idx_next        = idx_reg;
        pass2_next      = pass2_reg;
        found_next      = found_reg;
        fslot_next      = fslot_reg;
        exp_ok_next     = exp_ok_reg;
        exp_slot_next   = exp_slot_reg;
        old_ok_next     = old_ok_reg;
        old_slot_next   = old_slot_reg;
        oldest_next     = oldest_reg;
        freed_next      = freed_reg;
        o_status_next   = o_status_reg;
        o_slot_next     = o_slot_reg;
        o_key_next      = o_key_reg;
        o_addr_next     = o_addr_reg;
        o_exp_next      = o_exp_reg;
        o_note_next     = o_note_reg;
        o_freed_next    = o_freed_reg;
        o_live_next     = o_live_reg;
        wr_en           = 1'b0;
        wr_idx          = fslot_reg;

        if (cmd.load) begin
            walk_next   = '0;
            idx_next    = (in_kind == KIND_SWEEP) ? cursor_reg : '0;
            limit_next  = size_reg;
            if (in_kind == KIND_SWEEP) begin
                limit_next = (CMP_W'(in_budget) > CMP_W'(size_reg))
                             ? size_reg : CNT_W'(in_budget);
            end
            pass2_next  = 1'b0;
            found_next  = 1'b0;
            exp_ok_next = 1'b0;
            old_ok_next = 1'b0;
            oldest_next = '1;
            freed_next  = '0;
        end

        // A hit keeps the index so that the read registers hold that entry.
        if (cmd.step) begin
            walk_next = walk_reg + CNT_W'(1);
            idx_next  = stat.hit ? idx_reg : idx_reg + IDX_W'(1);
            if (!pass2_reg) begin
                case (kind_reg)
                    KIND_STORE: begin
                        if (is_live) begin
                            if (is_expired) begin
                                exp_ok_next   = 1'b1;
                                exp_slot_next = cur;
                            end else if (rd_exp_reg < oldest_reg) begin
                                old_ok_next   = 1'b1;
                                old_slot_next = cur;
                                oldest_next   = rd_exp_reg;
                            end
                        end
                        if (stat.hit) begin
                            found_next = 1'b1;
                            fslot_next = cur;
                        end
                    end
                    KIND_FKEY: begin
                        if (is_live && key_eq) begin
                            if (is_expired) begin
                                live_next[cur]  = 1'b0;
                                live_total_next = live_total_reg - CNT_W'(1);
                            end else begin
                                found_next = 1'b1;
                                fslot_next = cur;
                            end
                        end
                    end
                    KIND_FADDR: begin
                        if (stat.hit) begin
                            found_next = 1'b1;
                            fslot_next = cur;
                        end
                    end
                    default: begin
                        idx_next    = cursor_inc;
                        cursor_next = cursor_inc;
                        if (is_live && is_expired) begin
                            live_next[cur]  = 1'b0;
                            live_total_next = live_total_reg - CNT_W'(1);
                            freed_next      = freed_reg + CNT_W'(1);
                        end
                    end
                endcase
            end else if (stat.hit) begin
                found_next = 1'b1;
                fslot_next = cur;
            end
        end

        // End of a pass: a store without a key match gets a second pass.
        if (cmd.finish) begin
            if (stat.again) begin
                pass2_next = 1'b1;
                walk_next  = '0;
                idx_next   = '0;
            end
        end

        if (cmd.emit) begin
            o_slot_next   = '0;
            o_key_next    = '0;
            o_addr_next   = '0;
            o_exp_next    = '0;
            o_note_next   = '0;
            o_freed_next  = '0;
            o_status_next = ST_OK;
            if (size_reg == '0) begin
                o_status_next = ST_NOINIT;
            end else begin
                case (kind_reg)
                    KIND_STORE: begin
                        if (found_reg) begin
                            wr_en  = 1'b1;
                            wr_idx = fslot_reg;
                        end else if (exp_ok_reg) begin
                            wr_en  = 1'b1;
                            wr_idx = exp_slot_reg;
                        end else if (old_ok_reg) begin
                            wr_en  = 1'b1;
                            wr_idx = old_slot_reg;
                        end else begin
                            o_status_next = ST_LIMIT;
                        end
                        if (wr_en) begin
                            o_slot_next    = wr_idx;
                            live_next[wr_idx] = 1'b1;
                            if (!live_reg[wr_idx]) begin
                                live_total_next = live_total_reg + CNT_W'(1);
                            end
                        end
                    end
                    KIND_FKEY, KIND_FADDR: begin
                        if (found_reg) begin
                            o_slot_next = fslot_reg;
                            o_key_next  = WORD_W'(rd_key_reg);
                            o_addr_next = WORD_W'(rd_addr_reg);
                            o_exp_next  = rd_exp_reg;
                            o_note_next = rd_note_reg;
                        end else begin
                            o_status_next = ST_MISS;
                        end
                    end
                    default: o_freed_next = COUNT_W'(freed_reg);
                endcase
            end
            o_live_next = (size_reg == '0) ? '0 : COUNT_W'(live_total_next);
        end

        if (cfg_wr_en) begin
            size_next       = cfg_sat;
            live_next       = '0;
            cursor_next     = '0;
            live_total_next = '0;
        end
    end

    // Control and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg       <= '0;
            size_reg       <= '0;
            cursor_reg     <= '0;
            live_total_reg <= '0;
            o_status_reg   <= ST_NOINIT;
            o_slot_reg     <= '0;
            o_key_reg      <= '0;
            o_addr_reg     <= '0;
            o_exp_reg      <= '0;
            o_note_reg     <= '0;
            o_freed_reg    <= '0;
            o_live_reg     <= '0;
        end else begin
            live_reg       <= live_next;
            size_reg       <= size_next;
            cursor_reg     <= cursor_next;
            live_total_reg <= live_total_next;
            o_status_reg   <= o_status_next;
            o_slot_reg     <= o_slot_next;
            o_key_reg      <= o_key_next;
            o_addr_reg     <= o_addr_next;
            o_exp_reg      <= o_exp_next;
            o_note_reg     <= o_note_next;
            o_freed_reg    <= o_freed_next;
            o_live_reg     <= o_live_next;
        end
    end

    // Walk and payload registers.
    always_ff @(posedge aclk) begin
        walk_reg     <= walk_next;
        limit_reg    <= limit_next;
        idx_reg      <= idx_next;
        pass2_reg    <= pass2_next;
        found_reg    <= found_next;
        fslot_reg    <= fslot_next;
        exp_ok_reg   <= exp_ok_next;
        exp_slot_reg <= exp_slot_next;
        old_ok_reg   <= old_ok_next;
        old_slot_reg <= old_slot_next;
        oldest_reg   <= oldest_next;
        freed_reg    <= freed_next;
        if (cmd.load) begin
            kind_reg <= in_kind;
            now_reg  <= in_now;
            key_reg  <= in_key[KEY_BITS-1:0];
            addr_reg <= in_addr[ADDR_BITS-1:0];
            exp_reg  <= in_expiry;
            note_reg <= in_note;
        end
    end

    // Entry writes by a store, and the registered read at the next index.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_key[wr_idx]    <= key_reg;
            mem_addr[wr_idx]   <= addr_reg;
            mem_expiry[wr_idx] <= exp_reg;
            mem_note[wr_idx]   <= note_reg;
        end
        rd_key_reg  <= mem_key[idx_next];
        rd_addr_reg <= mem_addr[idx_next];
        rd_exp_reg  <= mem_expiry[idx_next];
        rd_note_reg <= mem_note[idx_next];
    end

    // Result fields.
    assign res_status = o_status_reg;
    assign res_slot   = SLOT_W'(o_slot_reg);
    assign res_key    = o_key_reg;
    assign res_addr   = o_addr_reg;
    assign res_expiry = o_exp_reg;
    assign res_note   = o_note_reg;
    assign res_freed  = o_freed_reg;
    assign res_live   = o_live_reg;
endmodule
`default_nettype wire

@@ rtl/core/ett_ctrl.sv @@
`default_nettype none
module ett_ctrl
    import ett_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  noinit,
    output logic       out_valid,
    input  wire logic  out_ready,
    output ett_cmd_t   cmd,
    input  wire ett_stat_t stat
);
    typedef enum logic [1:0] {IDLE, WALK, PASS, DONE} state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = valid_reg;

    // Sequencing of one operation.
    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = noinit ? DONE : WALK;
                end
            end
            WALK: begin
                if (stat.last) begin
                    state_next = PASS;
                end else begin
                    cmd.step = 1'b1;
                    if (stat.hit) begin
                        state_next = PASS;
                    end
                end
            end
            PASS: begin
                // Only a store that found no key match walks a second time.
                cmd.finish = 1'b1;
                state_next = stat.again ? WALK : DONE;
            end
            DONE: begin
                if (!valid_next) begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/expiring_ticket_table.sv @@
// Channel   | Handshake                 | Word
// s_        | s_axis_tvalid/tready      | kind..sweep_budget, 2+5*64+7 bits
// m_        | m_axis_tvalid/tready      | status..live_count, 2+6+4*64+7+7 bits
// cfg       | cfg_wr_en                 | table_size, 7 bits
// The walk reads one slot per cycle. A store walks up to twice (key match,
// then free slot), and the next word can be taken once its result is valid.
// A lookup walks at most table_size slots and a sweep at most its budget.
// Reset clears the table size, live bits, cursor and live count.
// A result waits in the output register while the next word is taken; an
// operation stalls before its result only while the previous one is unread.
`default_nettype none
module expiring_ticket_table
    import ett_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 64,
    parameter int ADDR_BITS   = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [6:0]    cfg_wr_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // kind[1:0], now_time[65:2], issuer_key[129:66], address_hint[193:130],
    // expiry_time[257:194], note_id[321:258], sweep_budget[328:322]
    input  wire logic [335:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // status[1:0], slot[7:2], found_key[71:8], found_address[135:72],
    // found_expiry[199:136], found_note[263:200], freed_count[270:264],
    // live_count[277:271]
    output logic [279:0]       m_axis_tdata
);
    ett_cmd_t  cmd;
    ett_stat_t stat;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic [WORD_W-1:0]   r_key, r_addr, r_exp, r_note;
    logic [COUNT_W-1:0]  r_freed, r_live;
    logic [COUNT_W-1:0]  size_reg;

    // Shadow of the size register for the not-initialized check.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '0;
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    ett_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .noinit    (size_reg == '0),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ett_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_axis_tdata[1:0]),
        .in_now      (s_axis_tdata[65:2]),
        .in_key      (s_axis_tdata[129:66]),
        .in_addr     (s_axis_tdata[193:130]),
        .in_expiry   (s_axis_tdata[257:194]),
        .in_note     (s_axis_tdata[321:258]),
        .in_budget   (s_axis_tdata[328:322]),
        .res_status  (r_status),
        .res_slot    (r_slot),
        .res_key     (r_key),
        .res_addr    (r_addr),
        .res_expiry  (r_exp),
        .res_note    (r_note),
        .res_freed   (r_freed),
        .res_live    (r_live)
    );

    assign m_axis_tdata = {2'b00, r_live, r_freed, r_note, r_exp, r_addr, r_key,
                           r_slot, r_status};
endmodule
`default_nettype wire
